@@ src/rmq_pkg.sv @@
// shared types, widths and helpers for the rotation matrix to quaternion block
package rmq_pkg;

  // sqrt radicand width: (big+16384)*4096, big <= 3*32767 -> below 2^29
  localparam int unsigned RadW = 30;
  // number of restoring sqrt steps (two radicand bits each)
  localparam int unsigned SqrtSteps = RadW / 2;
  // steps done per pipeline stage
  localparam int unsigned SqrtPerStage = 5;
  localparam int unsigned SqrtStages = SqrtSteps / SqrtPerStage;
  // root width
  localparam int unsigned RootW = 16;
  // off-diagonal sum magnitude width (|d| <= 65536)
  localparam int unsigned DiffW = 18;
  localparam int unsigned MagW = 17;

  // selected component code
  typedef enum logic [1:0] {
    PartW = 2'd0,
    PartX = 2'd1,
    PartY = 2'd2,
    PartZ = 2'd3
  } part_e;

  // saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [MagW+1:0] v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ src/rotation_matrix_to_quaternion.sv @@
// top level: rotation matrix to unit quaternion pipeline
//
// Takes one 3x3 matrix in signed Q2.14 per word and gives the quaternion
// (qw, qx, qy, qz) in Q2.14 plus the index of the component that came from
// the square root.
// Input: a word is taken at a rising edge with start_i high and busy_o low.
// busy_o is tied low: the pipeline takes a new word every cycle.
// Output: done_o is high for exactly one cycle with the result on the ports;
// the receiver cannot hold results off, and none is needed.
// Pipeline: 1 front stage, 3 square root stages, 6 divide stages and one
// output register.
// Throughput: one word per cycle, set by the fully pipelined root and divider.
// Reset: rst_ni clears all valid bits at once; words in flight are dropped.
module rotation_matrix_to_quaternion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m10_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m20_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m22_i,
  output logic               done_o,
  output logic signed [15:0] qw_o,
  output logic signed [15:0] qx_o,
  output logic signed [15:0] qy_o,
  output logic signed [15:0] qz_o,
  output logic [1:0]         largest_part_o
);

  logic                             f_vld, s_vld;
  rmq_pkg::part_e                   f_part, s_part, o_part;
  logic [rmq_pkg::RadW-1:0]         f_rad;
  logic [rmq_pkg::RootW-1:0]        s_root;
  logic signed [rmq_pkg::DiffW-1:0] f_d0, f_d1, f_d2, s_d0, s_d1, s_d2;

  assign busy_o = 1'b0;

  // diagonal combinations and selection
  rmq_front u_front (
    .clk_i, .rst_ni, .vld_i(start_i),
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .vld_o(f_vld), .part_o(f_part), .rad_o(f_rad),
    .d0_o(f_d0), .d1_o(f_d1), .d2_o(f_d2)
  );

  // square root of the chosen combination
  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni, .vld_i(f_vld), .part_i(f_part), .rad_i(f_rad),
    .d0_i(f_d0), .d1_i(f_d1), .d2_i(f_d2),
    .vld_o(s_vld), .part_o(s_part), .root_o(s_root),
    .d0_o(s_d0), .d1_o(s_d1), .d2_o(s_d2)
  );

  // divide the off-diagonal terms and assemble
  rmq_scale u_scale (
    .clk_i, .rst_ni, .vld_i(s_vld), .part_i(s_part), .root_i(s_root),
    .d0_i(s_d0), .d1_i(s_d1), .d2_i(s_d2),
    .vld_o(done_o), .qw_o, .qx_o, .qy_o, .qz_o, .part_o(o_part)
  );

  assign largest_part_o = o_part;

endmodule

@@ src/rmq_front.sv @@
// front stage: diagonal combinations, largest pick and off-diagonal terms
module rmq_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  logic signed [15:0]                m00_i,
  input  logic signed [15:0]                m01_i,
  input  logic signed [15:0]                m02_i,
  input  logic signed [15:0]                m10_i,
  input  logic signed [15:0]                m11_i,
  input  logic signed [15:0]                m12_i,
  input  logic signed [15:0]                m20_i,
  input  logic signed [15:0]                m21_i,
  input  logic signed [15:0]                m22_i,
  output logic                              vld_o,
  output rmq_pkg::part_e                    part_o,
  output logic [rmq_pkg::RadW-1:0]          rad_o,
  output logic signed [rmq_pkg::DiffW-1:0]  d0_o,
  output logic signed [rmq_pkg::DiffW-1:0]  d1_o,
  output logic signed [rmq_pkg::DiffW-1:0]  d2_o
);

  logic signed [17:0] tw, tx, ty, tz, big;
  logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  rmq_pkg::part_e part_d, part_q;
  logic [rmq_pkg::RadW-1:0] rad_d, rad_q;
  logic signed [rmq_pkg::DiffW-1:0] d0_d, d1_d, d2_d, d0_q, d1_q, d2_q;
  logic vld_q;
  logic [17:0] s_big;

  // diagonal combinations and strict-greater pick in w, x, y, z order
  always_comb begin
    e00 = 18'(m00_i); e01 = 18'(m01_i); e02 = 18'(m02_i);
    e10 = 18'(m10_i); e11 = 18'(m11_i); e12 = 18'(m12_i);
    e20 = 18'(m20_i); e21 = 18'(m21_i); e22 = 18'(m22_i);
    tw = e00 + e11 + e22;
    tx = e00 - e11 - e22;
    ty = e11 - e00 - e22;
    tz = e22 - e00 - e11;
    big = tw;
    part_d = rmq_pkg::PartW;
    if (tx > big) begin
      big = tx;
      part_d = rmq_pkg::PartX;
    end
    if (ty > big) begin
      big = ty;
      part_d = rmq_pkg::PartY;
    end
    if (tz > big) begin
      big = tz;
      part_d = rmq_pkg::PartZ;
    end
    s_big = big + 18'sd16384;
    rad_d = {s_big[rmq_pkg::RadW-13:0], 12'd0};
    case (part_d)
      rmq_pkg::PartW: begin
        d0_d = e12 - e21; d1_d = e20 - e02; d2_d = e01 - e10;
      end
      rmq_pkg::PartX: begin
        d0_d = e12 - e21; d1_d = e01 + e10; d2_d = e20 + e02;
      end
      rmq_pkg::PartY: begin
        d0_d = e20 - e02; d1_d = e01 + e10; d2_d = e12 + e21;
      end
      default: begin
        d0_d = e01 - e10; d1_d = e20 + e02; d2_d = e12 + e21;
      end
    endcase
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    rad_q  <= rad_d;
    d0_q   <= d0_d;
    d1_q   <= d1_d;
    d2_q   <= d2_d;
  end

  assign vld_o  = vld_q;
  assign part_o = part_q;
  assign rad_o  = rad_q;
  assign d0_o   = d0_q;
  assign d1_o   = d1_q;
  assign d2_o   = d2_q;

endmodule

@@ src/rmq_sqrt.sv @@
// pipelined restoring square root with round-to-nearest, side data carried along
module rmq_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  rmq_pkg::part_e                    part_i,
  input  logic [rmq_pkg::RadW-1:0]          rad_i,
  input  logic signed [rmq_pkg::DiffW-1:0]  d0_i,
  input  logic signed [rmq_pkg::DiffW-1:0]  d1_i,
  input  logic signed [rmq_pkg::DiffW-1:0]  d2_i,
  output logic                              vld_o,
  output rmq_pkg::part_e                    part_o,
  output logic [rmq_pkg::RootW-1:0]         root_o,
  output logic signed [rmq_pkg::DiffW-1:0]  d0_o,
  output logic signed [rmq_pkg::DiffW-1:0]  d1_o,
  output logic signed [rmq_pkg::DiffW-1:0]  d2_o
);

  localparam int unsigned NS = rmq_pkg::SqrtStages;
  localparam int unsigned RW = rmq_pkg::RadW;
  localparam int unsigned QW = rmq_pkg::RootW;

  // per-stage state: remaining radicand bits, partial remainder, partial root
  logic [NS:0]                         vld_q;
  rmq_pkg::part_e                      part_q [NS+1];
  logic [RW-1:0]                       rad_q  [NS+1];
  logic [RW/2+1:0]                     rem_q  [NS+1];
  logic [QW-1:0]                       root_q [NS+1];
  logic signed [rmq_pkg::DiffW-1:0]    da_q   [NS+1];
  logic signed [rmq_pkg::DiffW-1:0]    db_q   [NS+1];
  logic signed [rmq_pkg::DiffW-1:0]    dc_q   [NS+1];

  logic [RW-1:0]   rad_n  [NS];
  logic [RW/2+1:0] rem_n  [NS];
  logic [QW-1:0]   root_n [NS];

  // stage entry
  always_comb begin
    vld_q[0]  = vld_i;
    part_q[0] = part_i;
    rad_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    da_q[0]   = d0_i;
    db_q[0]   = d1_i;
    dc_q[0]   = d2_i;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    // a few digit steps per stage
    always_comb begin
      logic [RW/2+1:0] trial;
      logic [RW/2+1:0] r;
      logic [QW-1:0]   q;
      logic [RW-1:0]   a;
      r = rem_q[s];
      q = root_q[s];
      a = rad_q[s];
      for (int k = 0; k < rmq_pkg::SqrtPerStage; k++) begin
        r = {r[RW/2-1:0], a[RW-1:RW-2]};
        a = {a[RW-3:0], 2'b00};
        // partial root stays below 2^15, so its top bit is always clear
        trial = {q[QW-2:0], 2'b01};
        if (r >= trial) begin
          r = r - trial;
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
      end
      rad_n[s]  = a;
      rem_n[s]  = r;
      root_n[s] = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      part_q[s+1] <= part_q[s];
      rad_q[s+1]  <= rad_n[s];
      rem_q[s+1]  <= rem_n[s];
      root_q[s+1] <= root_n[s];
      da_q[s+1]   <= da_q[s];
      db_q[s+1]   <= db_q[s];
      dc_q[s+1]   <= dc_q[s];
    end
  end

  // round up when remainder exceeds root
  assign root_o = (rem_q[NS] > (RW/2+2)'(root_q[NS])) ? root_q[NS] + 1'b1 : root_q[NS];
  assign vld_o  = vld_q[NS];
  assign part_o = part_q[NS];
  assign d0_o   = da_q[NS];
  assign d1_o   = db_q[NS];
  assign d2_o   = dc_q[NS];

endmodule

@@ src/rmq_scale.sv @@
// pipelined divide of the three off-diagonal terms by twice the root
module rmq_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  rmq_pkg::part_e                    part_i,
  input  logic [rmq_pkg::RootW-1:0]         root_i,
  input  logic signed [rmq_pkg::DiffW-1:0]  d0_i,
  input  logic signed [rmq_pkg::DiffW-1:0]  d1_i,
  input  logic signed [rmq_pkg::DiffW-1:0]  d2_i,
  output logic                              vld_o,
  output logic signed [15:0]                qw_o,
  output logic signed [15:0]                qx_o,
  output logic signed [15:0]                qy_o,
  output logic signed [15:0]                qz_o,
  output rmq_pkg::part_e                    part_o
);

  // q = floor((mag*8192 + b) / (2b)); numerator < 2^31, quotient < 2^17
  localparam int unsigned NW = 31;
  localparam int unsigned QW = 17;
  localparam int unsigned BPS = 3;           // quotient bits per stage
  localparam int unsigned NS = (QW + BPS - 1) / BPS;
  localparam int unsigned DW = rmq_pkg::RootW + 1;
  localparam int unsigned RMW = DW + 1;

  logic [NS:0]              vld_q;
  rmq_pkg::part_e           part_q [NS+1];
  logic [rmq_pkg::RootW-1:0] b_q   [NS+1];
  logic [2:0]               neg_q  [NS+1];
  logic [NW-1:0]            num_q  [NS+1][3];
  logic [RMW-1:0]           rem_q  [NS+1][3];
  logic [QW-1:0]            quo_q  [NS+1][3];

  logic [NW-1:0]  num_n [NS][3];
  logic [RMW-1:0] rem_n [NS][3];
  logic [QW-1:0]  quo_n [NS][3];

  logic signed [rmq_pkg::DiffW-1:0] din [3];
  logic [rmq_pkg::MagW-1:0] mag [3];

  // entry: magnitudes and numerators, low numerator bits left-aligned for long division
  always_comb begin
    din[0] = d0_i; din[1] = d1_i; din[2] = d2_i;
    vld_q[0]  = vld_i;
    part_q[0] = part_i;
    b_q[0]    = root_i;
    for (int j = 0; j < 3; j++) begin
      mag[j] = din[j][rmq_pkg::DiffW-1] ? rmq_pkg::MagW'(-din[j])
                                        : rmq_pkg::MagW'(din[j]);
      neg_q[0][j] = din[j][rmq_pkg::DiffW-1];
      num_q[0][j] = ({1'b0, mag[j], 13'd0} + NW'(root_i)) << (NW - QW);
      rem_q[0][j] = RMW'(({1'b0, mag[j], 13'd0} + NW'(root_i)) >> QW);
      quo_q[0][j] = '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    // restoring division, a few quotient bits per stage
    always_comb begin
      logic [RMW-1:0] r;
      logic [NW-1:0]  n;
      logic [QW-1:0]  q;
      logic [DW-1:0]  dv;
      dv = {b_q[s], 1'b0};
      for (int j = 0; j < 3; j++) begin
        r = rem_q[s][j];
        n = num_q[s][j];
        q = quo_q[s][j];
        for (int k = 0; k < BPS; k++) begin
          if (s * BPS + k < QW) begin
            r = {r[RMW-2:0], n[NW-1]};
            n = {n[NW-2:0], 1'b0};
            if (r >= RMW'(dv)) begin
              r = r - RMW'(dv);
              q = {q[QW-2:0], 1'b1};
            end else begin
              q = {q[QW-2:0], 1'b0};
            end
          end
        end
        num_n[s][j] = n;
        rem_n[s][j] = r;
        quo_n[s][j] = q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      part_q[s+1] <= part_q[s];
      b_q[s+1]    <= b_q[s];
      neg_q[s+1]  <= neg_q[s];
      num_q[s+1]  <= num_n[s];
      rem_q[s+1]  <= rem_n[s];
      quo_q[s+1]  <= quo_n[s];
    end
  end

  // sign, saturate and place into the component slots
  logic signed [15:0] o [3];
  logic signed [15:0] bq;
  logic signed [rmq_pkg::MagW+1:0] sv [3];
  logic signed [15:0] qw_d, qx_d, qy_d, qz_d;
  logic vld_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  rmq_pkg::part_e part_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sv[j] = neg_q[NS][j] ? -$signed({2'b00, quo_q[NS][j]})
                           : $signed({2'b00, quo_q[NS][j]});
      o[j]  = rmq_pkg::sat16(sv[j]);
    end
    bq = rmq_pkg::sat16($signed({3'b000, b_q[NS]}));
    case (part_q[NS])
      rmq_pkg::PartW: begin
        qw_d = bq; qx_d = o[0]; qy_d = o[1]; qz_d = o[2];
      end
      rmq_pkg::PartX: begin
        qx_d = bq; qw_d = o[0]; qy_d = o[1]; qz_d = o[2];
      end
      rmq_pkg::PartY: begin
        qy_d = bq; qw_d = o[0]; qx_d = o[1]; qz_d = o[2];
      end
      default: begin
        qz_d = bq; qw_d = o[0]; qx_d = o[1]; qy_d = o[2];
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    qw_r   <= qw_d;
    qx_r   <= qx_d;
    qy_r   <= qy_d;
    qz_r   <= qz_d;
    part_r <= part_q[NS];
  end

  assign vld_o  = vld_r;
  assign qw_o   = qw_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;
  assign qz_o   = qz_r;
  assign part_o = part_r;

endmodule

@@ src/rmq_checker.sv @@
// port-level checks for the quaternion pipeline, bound to the top level
module rmq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [15:0] qw_o,
  input logic signed [15:0] qx_o,
  input logic signed [15:0] qy_o,
  input logic signed [15:0] qz_o,
  input logic [1:0]         largest_part_o
);

  // a word accepted now is done after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##11 done_o) else $error("missing result");

  // the square root component is at least one half when it is w or x
  a_root_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && largest_part_o == rmq_pkg::PartW) |-> qw_o >= 16'sd8192)
    else $error("w root below one half");

  a_root_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && largest_part_o == rmq_pkg::PartX) |-> qx_o >= 16'sd8192)
    else $error("x root below one half");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 11)) else $error("spurious result");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
